@@ design/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes, types and codes of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Sizes of the store.
  localparam int unsigned ENTRIES    = 8;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CAP_BITS   = 4;
  localparam int unsigned SLOT_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W      = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int unsigned LINE_W     = KEY_BITS + VALUE_BITS;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CAP_BITS-1:0]   cap_t;
  typedef logic [LINE_W-1:0]     line_t;

  // Capacity after reset.
  localparam cap_t CAP_RESET = cap_t'(8);

  // Operation codes.
  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_PUT  = 2'd1,
    OP_LIST = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Update request from the controller to the directory.
  typedef struct packed {
    logic  touch;   // make slot the most recent entry
    logic  insert;  // insert key into the first free slot
    logic  evict;   // drop the least recently used entry first
    slot_t slot;
    key_t  key;
  } dir_cmd_t;

  // Lookup results from the directory.
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    slot_t lru_slot;
    logic  evict_need;
    slot_t ins_slot;
    slot_t list_slot;
    cnt_t  count;
  } dir_stat_t;

endpackage

@@ design/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A get or a put is accepted while the directory matches the key against every
// tag and the line RAM read starts; in the response state that follows, the read
// data forms the result and the directory and RAM are updated. A key listing
// of N stored keys emits one key per cycle while the result channel does not
// stall, paced by the single read port of the line RAM. There is no clearing
// pass after reset; the capacity register can be written at any idle time and
// its port is always ready.
module lru_key_value_cache (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Capacity register write.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  lkv_pkg::cap_t         cfg_data_i,
  // Requests.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  lkv_pkg::key_t         key_i,
  input  lkv_pkg::value_t       value_i,
  // Results.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output lkv_pkg::value_t       read_value_o,
  output lkv_pkg::key_t         listed_key_o,
  output logic                  key_valid_o,
  output logic                  evicted_o,
  output lkv_pkg::key_t         evicted_key_o,
  output logic                  last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e state_q, state_d;

  lkv_pkg::cap_t   cap_q;
  lkv_pkg::op_e    op_q;
  lkv_pkg::key_t   key_q;
  lkv_pkg::value_t value_q;
  lkv_pkg::cnt_t   list_rank_q, list_rank_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            hit_q, hit_d;
  lkv_pkg::value_t read_value_q, read_value_d;
  lkv_pkg::key_t   listed_key_q, listed_key_d;
  logic            key_valid_q, key_valid_d;
  logic            evicted_q, evicted_d;
  lkv_pkg::key_t   evicted_key_q, evicted_key_d;
  logic            last_q, last_d;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic               list_last;
  lkv_pkg::op_e       in_op;
  lkv_pkg::key_t      lookup_key;
  lkv_pkg::cnt_t      list_rank_in;
  lkv_pkg::dir_cmd_t  dir_cmd;
  lkv_pkg::dir_stat_t dir_stat;

  logic           ram_we, ram_re;
  lkv_pkg::slot_t ram_waddr, ram_raddr;
  lkv_pkg::line_t ram_wdata, ram_rdata;
  lkv_pkg::key_t  rd_key;
  lkv_pkg::value_t rd_value;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_op       = lkv_pkg::op_e'(operation_i);

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // The directory looks up the incoming key while idle and the held key after.
  assign lookup_key   = in_ready_o ? key_i : key_q;
  assign list_rank_in = in_ready_o ? '0 : lkv_pkg::cnt_t'(list_rank_q + 1'b1);
  assign list_last    = (lkv_pkg::cnt_t'(list_rank_q + 1'b1) == dir_stat.count);

  lkv_dir u_dir (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_key_i (lookup_key),
    .cap_i        (cap_q),
    .list_rank_i  (list_rank_in),
    .cmd_i        (dir_cmd),
    .stat_o       (dir_stat)
  );

  lkv_ram #(
    .WIDTH (lkv_pkg::LINE_W),
    .DEPTH (lkv_pkg::ENTRIES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key   = ram_rdata[lkv_pkg::LINE_W-1 -: lkv_pkg::KEY_BITS];
  assign rd_value = ram_rdata[lkv_pkg::VALUE_BITS-1:0];

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Sequencer: RAM read on accept, result and write-back in the response state.
  always_comb begin
    state_d       = state_q;
    list_rank_d   = list_rank_q;
    emit          = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = dir_stat.list_slot;
    ram_we        = 1'b0;
    ram_waddr     = dir_stat.ins_slot;
    ram_wdata     = {key_q, value_q};
    dir_cmd       = '0;
    dir_cmd.key   = key_q;
    dir_cmd.slot  = dir_stat.hit_slot;
    hit_d         = 1'b0;
    read_value_d  = '0;
    listed_key_d  = '0;
    key_valid_d   = 1'b0;
    evicted_d     = 1'b0;
    evicted_key_d = '0;
    last_d        = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        list_rank_d = '0;
        if (accept) begin
          ram_re = 1'b1;
          case (in_op)
            lkv_pkg::OP_GET: ram_raddr = dir_stat.hit_slot;
            lkv_pkg::OP_PUT: ram_raddr = dir_stat.lru_slot;
            default:         ram_raddr = dir_stat.list_slot;
          endcase
          if ((in_op == lkv_pkg::OP_LIST) && (dir_stat.count != '0)) begin
            state_d = S_LIST;
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            lkv_pkg::OP_GET: begin
              hit_d         = dir_stat.hit;
              read_value_d  = dir_stat.hit ? rd_value : '0;
              dir_cmd.touch = dir_stat.hit;
            end
            lkv_pkg::OP_PUT: begin
              hit_d          = dir_stat.hit;
              evicted_d      = !dir_stat.hit && dir_stat.evict_need;
              evicted_key_d  = (!dir_stat.hit && dir_stat.evict_need) ? rd_key : '0;
              dir_cmd.touch  = dir_stat.hit;
              dir_cmd.insert = !dir_stat.hit;
              dir_cmd.evict  = !dir_stat.hit && dir_stat.evict_need;
              ram_we         = 1'b1;
              ram_waddr      = dir_stat.hit ? dir_stat.hit_slot : dir_stat.ins_slot;
            end
            default: begin
              // Empty listing and the unused code give an all-zero result with last set.
            end
          endcase
        end
      end

      S_LIST: begin
        if (out_free) begin
          // Emit one key and fetch the key of the next rank.
          emit         = 1'b1;
          ram_re       = 1'b1;
          listed_key_d = rd_key;
          key_valid_d  = 1'b1;
          last_d       = list_last;
          list_rank_d  = lkv_pkg::cnt_t'(list_rank_q + 1'b1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      list_rank_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      list_rank_q <= list_rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      hit_q         <= hit_d;
      read_value_q  <= read_value_d;
      listed_key_q  <= listed_key_d;
      key_valid_q   <= key_valid_d;
      evicted_q     <= evicted_d;
      evicted_key_q <= evicted_key_d;
      last_q        <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign listed_key_o  = listed_key_q;
  assign key_valid_o   = key_valid_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;
  assign last_o        = last_q;

  // The entry count never exceeds the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_stat.count <= lkv_pkg::cnt_t'(lkv_pkg::ENTRIES))
    else $error("entry count above the number of slots");

  // An accepted request keeps the request side closed for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted twice in a row");

  // An eviction is only reported for a put that missed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(evicted_o && (hit_o || key_valid_o)))
    else $error("eviction reported on a hit or a listing");

endmodule

@@ design/lkv_ram.sv @@
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lkv_dir.sv @@
// ----------------------------------------------------------------------------
// lkv_dir
// Directory of the cache: key tags, valid bits, recency ranks and the entry
// count, with the associative lookup and the recency update.
// ----------------------------------------------------------------------------
module lkv_dir (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkv_pkg::key_t     lookup_key_i,
  input  lkv_pkg::cap_t     cap_i,
  input  lkv_pkg::cnt_t     list_rank_i,
  input  lkv_pkg::dir_cmd_t cmd_i,
  output lkv_pkg::dir_stat_t stat_o
);

  lkv_pkg::key_t  tag_q  [lkv_pkg::ENTRIES];
  lkv_pkg::slot_t rank_q [lkv_pkg::ENTRIES];
  lkv_pkg::slot_t rank_d [lkv_pkg::ENTRIES];
  logic [lkv_pkg::ENTRIES-1:0] valid_q, valid_d;
  lkv_pkg::cnt_t count_q, count_d;

  logic [lkv_pkg::ENTRIES-1:0] hit_vec, lru_vec, list_vec, free_vec, lru_dec;
  logic           hit;
  lkv_pkg::slot_t hit_slot, lru_slot, list_slot, ins_slot;
  logic           evict_need;

  // Associative compare and rank match, one tag comparator per entry.
  always_comb begin
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      hit_vec[i]  = valid_q[i] && (tag_q[i] == lookup_key_i);
      lru_vec[i]  = valid_q[i] && (rank_q[i] == '0);
      list_vec[i] = valid_q[i] &&
                    (lkv_pkg::cnt_t'(rank_q[i]) == list_rank_i);
    end
  end

  // The store is full when the count reaches the capacity; a capacity of
  // zero acts as one and one above the entry count acts as the entry count.
  assign evict_need = (count_q != '0) &&
                      ((cap_i == '0) ||
                       (lkv_pkg::CMP_W'(count_q) >= lkv_pkg::CMP_W'(cap_i)) ||
                       (count_q >= lkv_pkg::cnt_t'(lkv_pkg::ENTRIES)));

  // Lowest-index encoders.
  always_comb begin
    hit_slot  = '0;
    lru_slot  = '0;
    list_slot = '0;
    for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_slot = lkv_pkg::SLOT_W'(i);
      end
      if (lru_vec[i]) begin
        lru_slot = lkv_pkg::SLOT_W'(i);
      end
      if (list_vec[i]) begin
        list_slot = lkv_pkg::SLOT_W'(i);
      end
    end
  end

  assign hit = |hit_vec;

  // First free slot, counting the entry that an eviction will release.
  always_comb begin
    lru_dec  = '0;
    lru_dec[lru_slot] = evict_need;
    free_vec = ~(valid_q & ~lru_dec);
    ins_slot = '0;
    for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        ins_slot = lkv_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    stat_o.hit        = hit;
    stat_o.hit_slot   = hit_slot;
    stat_o.lru_slot   = lru_slot;
    stat_o.evict_need = evict_need;
    stat_o.ins_slot   = ins_slot;
    stat_o.list_slot  = list_slot;
    stat_o.count      = count_q;
  end

  // Recency and occupancy update.
  always_comb begin
    lkv_pkg::slot_t rank_cur;
    lkv_pkg::cnt_t  count_after;
    rank_cur    = rank_q[cmd_i.slot];
    count_after = count_q;
    valid_d     = valid_q;
    count_d     = count_q;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.touch) begin
      // Entries more recent than the touched one move down by one.
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] > rank_cur)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end
      end
      rank_d[cmd_i.slot] = lkv_pkg::SLOT_W'(count_q - 1'b1);
    end
    if (cmd_i.insert) begin
      if (cmd_i.evict) begin
        // Drop the oldest entry and age the rest toward rank zero.
        valid_d[lru_slot] = 1'b0;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (valid_q[i] && (rank_q[i] != '0)) begin
            rank_d[i] = rank_q[i] - 1'b1;
          end
        end
        count_after = count_q - 1'b1;
      end
      valid_d[ins_slot] = 1'b1;
      rank_d[ins_slot]  = lkv_pkg::SLOT_W'(count_after);
      count_d           = count_after + 1'b1;
    end
  end

  // Control state of the directory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Key tags are written on insert only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      tag_q[ins_slot] <= cmd_i.key;
    end
  end

endmodule
